[design/oriented_plane_normal_macros.svh]
// ----------------------------------------------------------------------------
// oriented_plane_normal_macros
// Assertion macros for the oriented plane normal block.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_PLANE_NORMAL_MACROS_SVH
`define ORIENTED_PLANE_NORMAL_MACROS_SVH
`ifndef ASSERT_OFF
`define OPN_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OPN_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define OPN_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define OPN_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

[design/opn_pkg.sv]
// ----------------------------------------------------------------------------
// opn_pkg
// Shared widths and pipeline constants for the oriented plane normal block.
// ----------------------------------------------------------------------------
package opn_pkg;
    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 15;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int NN_W    = 2 * CROSS_W + 2;
    localparam int DOT_W   = CROSS_W + DIFF_W + 2;
    localparam int NUM_W   = DOT_W + 16;
    localparam int QT_BITS = 33;
    localparam int QN_BITS = NORMAL_FRAC_BITS + 1;
    // n_i^2 * 2^(2F+2) / |n|^2 never exceeds 2^(2F+2)
    localparam int QY_BITS = 2 * NORMAL_FRAC_BITS + 3;
    localparam int YN_W    = NN_W + 2 * NORMAL_FRAC_BITS + 2;
    localparam int DIV_ST  = (QT_BITS > QY_BITS) ? QT_BITS : QY_BITS;
    localparam int DV_W    = (YN_W > NN_W + DIV_ST) ? YN_W : NN_W + DIV_ST;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
endpackage

[design/oriented_plane_normal.sv]
// ----------------------------------------------------------------------------
// oriented_plane_normal
// Oriented unit plane normal and plane parameter from four points.
// ----------------------------------------------------------------------------
// Usage: drive the twelve coordinates and pulse start; busy is always low, so a
// request is taken in every cycle that start is high.
// Each request gives exactly one result, shown for one cycle with done high:
// normal_x/y/z (Q1.15), plane_param (Q16.16, saturated) and degenerate.
// The result is registered through three front stages, one set-up stage,
// DIV_ST shift-and-subtract divide stages, one rounding stage and
// QN_BITS + 1 square root stages; the outputs are combinational.
// Throughput is one request per cycle; every divide and square root bit is an
// unrolled pipeline stage with one compare and subtract.
// Reset clears all valid bits; requests in flight are dropped.
// The receiver cannot stall, and the pipeline never holds.
// ----------------------------------------------------------------------------
`include "oriented_plane_normal_macros.svh"
module oriented_plane_normal (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  opn_pkg::coord_t p1_x, input opn_pkg::coord_t p1_y, input opn_pkg::coord_t p1_z,
    input  opn_pkg::coord_t p2_x, input opn_pkg::coord_t p2_y, input opn_pkg::coord_t p2_z,
    input  opn_pkg::coord_t p3_x, input opn_pkg::coord_t p3_y, input opn_pkg::coord_t p3_z,
    input  opn_pkg::coord_t ref_x, input opn_pkg::coord_t ref_y, input opn_pkg::coord_t ref_z,
    output logic done,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [31:0] plane_param,
    output logic degenerate
);
    import opn_pkg::*;

    localparam int NST = DIV_ST + 1 + QN_BITS + 1;
    localparam logic [QN_BITS-1:0] NLIM_RAW = QN_BITS'((1 << NORMAL_FRAC_BITS) - 1);
    localparam logic [QN_BITS-1:0] NLIM = (NORMAL_FRAC_BITS > 15) ? QN_BITS'(32767) : NLIM_RAW;

    typedef struct packed {
        logic                      deg;
        logic                      tneg;
        logic signed [CROSS_W-1:0] n0, n1, n2;
        logic [NN_W-1:0]           nn;
        logic [NUM_W-1:0]          num;         // running remainder of the t divide
        logic [QT_BITS:0]          q;
        logic [YN_W-1:0]           dx, dy, dz;  // remainders of n_i^2 divides
        logic [QY_BITS-1:0]        yx, yy, yz;  // quotient, then root remainder
        logic [QN_BITS:0]          qx, qy, qz;  // roots of the scaled quotients
    } st_t;

    // stage 1: differences
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] a_reg [3];
    logic signed [DIFF_W-1:0] b_reg [3];
    logic signed [DIFF_W-1:0] r_reg [3];
    // stage 2: cross product
    logic                      v2_reg;
    logic signed [CROSS_W-1:0] n2_reg [3];
    logic signed [DIFF_W-1:0]  r2_reg [3];
    // stage 3: squares and dot terms
    logic                      v3_reg;
    logic signed [CROSS_W-1:0] n3_reg [3];
    logic [NN_W-1:0]           sq_reg [3];
    logic signed [DOT_W-1:0]   dp_reg [3];
    // stage 4 onward: set-up stage, then unrolled compare stages
    logic [NST:0] pv_reg;
    st_t pipe_reg [NST+1];
    st_t pipe_next [NST+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0] <= DIFF_W'(p1_x) - DIFF_W'(p2_x);
        a_reg[1] <= DIFF_W'(p1_y) - DIFF_W'(p2_y);
        a_reg[2] <= DIFF_W'(p1_z) - DIFF_W'(p2_z);
        b_reg[0] <= DIFF_W'(p1_x) - DIFF_W'(p3_x);
        b_reg[1] <= DIFF_W'(p1_y) - DIFF_W'(p3_y);
        b_reg[2] <= DIFF_W'(p1_z) - DIFF_W'(p3_z);
        r_reg[0] <= DIFF_W'(ref_x) - DIFF_W'(p1_x);
        r_reg[1] <= DIFF_W'(ref_y) - DIFF_W'(p1_y);
        r_reg[2] <= DIFF_W'(ref_z) - DIFF_W'(p1_z);
        n2_reg[0] <= CROSS_W'(a_reg[1] * b_reg[2]) - CROSS_W'(a_reg[2] * b_reg[1]);
        n2_reg[1] <= CROSS_W'(a_reg[2] * b_reg[0]) - CROSS_W'(a_reg[0] * b_reg[2]);
        n2_reg[2] <= CROSS_W'(a_reg[0] * b_reg[1]) - CROSS_W'(a_reg[1] * b_reg[0]);
        r2_reg <= r_reg;
        for (int i = 0; i < 3; i++)
        begin
            n3_reg[i] <= n2_reg[i];
            sq_reg[i] <= NN_W'(n2_reg[i] * n2_reg[i]);
            dp_reg[i] <= DOT_W'(n2_reg[i] * r2_reg[i]);
        end
    end

    // stage 4 builds the operand set; later stages resolve one bit each, but for the rounding stage
    st_t s0_next;
    logic signed [DOT_W-1:0] dot_w;
    logic [DOT_W-1:0]        mag_w;
    always_comb
    begin
        dot_w = dp_reg[0] + dp_reg[1] + dp_reg[2];
        mag_w = dot_w[DOT_W-1] ? DOT_W'(-dot_w) : DOT_W'(dot_w);
        s0_next = '0;
        s0_next.n0   = n3_reg[0];
        s0_next.n1   = n3_reg[1];
        s0_next.n2   = n3_reg[2];
        s0_next.nn   = sq_reg[0] + sq_reg[1] + sq_reg[2];
        s0_next.deg  = (n3_reg[0] == '0) && (n3_reg[1] == '0) && (n3_reg[2] == '0);
        s0_next.tneg = !dot_w[DOT_W-1] && (dot_w != '0);
        s0_next.num  = {mag_w, 16'd0};
        s0_next.dx   = YN_W'(sq_reg[0]) << (2 * NORMAL_FRAC_BITS + 2);
        s0_next.dy   = YN_W'(sq_reg[1]) << (2 * NORMAL_FRAC_BITS + 2);
        s0_next.dz   = YN_W'(sq_reg[2]) << (2 * NORMAL_FRAC_BITS + 2);
    end

    function automatic void t_step(input logic [QT_BITS:0] q,
                                   input logic [NUM_W-1:0] rem,
                                   input logic [NN_W-1:0] nn,
                                   input int k,
                                   output logic [QT_BITS:0] q_o,
                                   output logic [NUM_W-1:0] rem_o);
        logic [DV_W-1:0] d;
        d = DV_W'(nn) << k;
        if (d <= DV_W'(rem))
        begin
            q_o   = q | ((QT_BITS+1)'(1) << k);
            rem_o = NUM_W'(DV_W'(rem) - d);
        end
        else
        begin
            q_o   = q;
            rem_o = rem;
        end
    endfunction

    function automatic void y_step(input logic [QY_BITS-1:0] y,
                                   input logic [YN_W-1:0] rem,
                                   input logic [NN_W-1:0] nn,
                                   input int k,
                                   output logic [QY_BITS-1:0] y_o,
                                   output logic [YN_W-1:0] rem_o);
        logic [DV_W-1:0] d;
        d = DV_W'(nn) << k;
        if (d <= DV_W'(rem))
        begin
            y_o   = y | (QY_BITS'(1) << k);
            rem_o = YN_W'(DV_W'(rem) - d);
        end
        else
        begin
            y_o   = y;
            rem_o = rem;
        end
    endfunction

    // digit-by-digit square root: trial (2r + 2^b) * 2^b against the remainder
    function automatic void r_step(input logic [QN_BITS:0] r,
                                   input logic [QY_BITS-1:0] rem,
                                   input int b,
                                   output logic [QN_BITS:0] r_o,
                                   output logic [QY_BITS-1:0] rem_o);
        logic [2*QN_BITS+1:0] d;
        d = ((2*QN_BITS+2)'(r) << (b + 1)) | ((2*QN_BITS+2)'(1) << (2 * b));
        if (d <= (2*QN_BITS+2)'(rem))
        begin
            r_o   = r | ((QN_BITS+1)'(1) << b);
            rem_o = QY_BITS'((2*QN_BITS+2)'(rem) - d);
        end
        else
        begin
            r_o   = r;
            rem_o = rem;
        end
    endfunction

    always_comb
    begin
        pipe_next[0] = s0_next;
        for (int s = 1; s <= NST; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            if (s <= DIV_ST)
            begin
                if (DIV_ST - s < QT_BITS)
                    t_step(pipe_reg[s-1].q, pipe_reg[s-1].num, pipe_reg[s-1].nn, DIV_ST - s,
                           pipe_next[s].q, pipe_next[s].num);
                if (DIV_ST - s < QY_BITS)
                begin
                    y_step(pipe_reg[s-1].yx, pipe_reg[s-1].dx, pipe_reg[s-1].nn, DIV_ST - s,
                           pipe_next[s].yx, pipe_next[s].dx);
                    y_step(pipe_reg[s-1].yy, pipe_reg[s-1].dy, pipe_reg[s-1].nn, DIV_ST - s,
                           pipe_next[s].yy, pipe_next[s].dy);
                    y_step(pipe_reg[s-1].yz, pipe_reg[s-1].dz, pipe_reg[s-1].nn, DIV_ST - s,
                           pipe_next[s].yz, pipe_next[s].dz);
                end
            end
            else if (s == DIV_ST + 1)
            begin
                // round t to nearest, ties away from zero
                if ((DV_W'(pipe_reg[s-1].num) << 1) >= DV_W'(pipe_reg[s-1].nn))
                    pipe_next[s].q = pipe_reg[s-1].q + 1'b1;
            end
            else
            begin
                r_step(pipe_reg[s-1].qx, pipe_reg[s-1].yx, NST - s,
                       pipe_next[s].qx, pipe_next[s].yx);
                r_step(pipe_reg[s-1].qy, pipe_reg[s-1].yy, NST - s,
                       pipe_next[s].qy, pipe_next[s].yy);
                r_step(pipe_reg[s-1].qz, pipe_reg[s-1].yz, NST - s,
                       pipe_next[s].qz, pipe_next[s].yz);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[NST-1:0], v3_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    // the root is of four times the target, so halve it with rounding
    function automatic logic [15:0] fin_comp(input logic [QN_BITS:0] r,
                                             input logic signed [CROSS_W-1:0] n,
                                             input logic flip);
        logic [QN_BITS+1:0] c;
        c = ((QN_BITS+2)'(r) + (QN_BITS+2)'(1)) >> 1;
        if (c > (QN_BITS+2)'(NLIM))
            c = (QN_BITS+2)'(NLIM);
        return ((n[CROSS_W-1]) != flip) ? 16'(-c) : 16'(c);
    endfunction

    st_t o;
    assign o = pipe_reg[NST];
    assign done       = pv_reg[NST];
    assign degenerate = o.deg;
    always_comb
    begin
        if (o.deg)
        begin
            normal_x = '0;
            normal_y = '0;
            normal_z = '0;
            plane_param = '0;
        end
        else
        begin
            normal_x = fin_comp(o.qx, o.n0, o.tneg);
            normal_y = fin_comp(o.qy, o.n1, o.tneg);
            normal_z = fin_comp(o.qz, o.n2, o.tneg);
            if (o.tneg)
                plane_param = (o.q > (QT_BITS+1)'(33'h080000000)) ? 32'h80000000
                                                                   : 32'(-o.q);
            else
                plane_param = (o.q > (QT_BITS+1)'(33'h07fffffff)) ? 32'h7fffffff : 32'(o.q);
        end
    end

    logic res_zero;
    assign res_zero = (plane_param == '0) && (normal_x == '0) && (normal_y == '0)
                      && (normal_z == '0);

    `OPN_ASSERT_NEXT(a_start_v1, clk, rst_n, start, v1_reg, "request lost at entry")
    `OPN_ASSERT_IMPL(a_deg_zero, clk, rst_n, (done && degenerate) |-> res_zero, "degenerate not zero")
    `OPN_ASSERT_IMPL(a_no_busy, clk, rst_n, !busy, "busy raised")
endmodule

[tb/tb_oriented_plane_normal.sv]
// ----------------------------------------------------------------------------
// tb_oriented_plane_normal
// Self-checking bench: drives point quadruples with random request gaps,
// predicts the oriented unit normal, plane parameter and degenerate flag with
// wide exact arithmetic, and compares every done strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_oriented_plane_normal;
    timeunit 1ns;
    timeprecision 1ps;

    import opn_pkg::*;

    typedef coord_t coords_t [12];

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] pp;
        logic               deg;
    } plane_res_t;

    class plane_scoreboard;
        plane_res_t pending[$];
        int         errors;
        int         n_checked;
        int         n_degenerate;
        int         n_flipped;
        int         n_saturated;

        function new();
            errors = 0;
            n_checked = 0;
            n_degenerate = 0;
            n_flipped = 0;
            n_saturated = 0;
        endfunction

        // rounded |n_i| * 2^15 / sqrt(N), clamped, then signed
        function logic [15:0] unit_component(longint ni, logic [255:0] nn, bit flip);
            logic [255:0] m;
            logic [255:0] tgt;
            logic [255:0] q;
            logic [255:0] c;
            logic [255:0] h;
            m = (ni < 0) ? 256'(-ni) : 256'(ni);
            tgt = (m * m) << (2 * NORMAL_FRAC_BITS);
            q = '0;
            for (int b = NORMAL_FRAC_BITS; b >= 0; b--)
            begin
                c = q | (256'(1) << b);
                if (c * c * nn <= tgt)
                    q = c;
            end
            h = 2 * q + 1;
            if (h * h * nn <= (tgt << 2))
                q = q + 1;
            if (q > 32767)
                q = 32767;
            if ((ni < 0) != flip)
                q = -q;
            return q[15:0];
        endfunction

        function void note_request(coords_t c);
            longint       p[4][3];
            longint       a[3];
            longint       b[3];
            longint       n[3];
            longint       dotv;
            logic [255:0] nn;
            logic [255:0] m;
            logic [255:0] num;
            logic [255:0] quo;
            logic [255:0] rem;
            bit           tneg;
            plane_res_t   r;
            for (int k = 0; k < 4; k++)
                for (int i = 0; i < 3; i++)
                    p[k][i] = c[k * 3 + i];
            for (int i = 0; i < 3; i++)
            begin
                a[i] = p[0][i] - p[1][i];
                b[i] = p[0][i] - p[2][i];
            end
            n[0] = a[1] * b[2] - a[2] * b[1];
            n[1] = a[2] * b[0] - a[0] * b[2];
            n[2] = a[0] * b[1] - a[1] * b[0];
            if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            begin
                r = '{nx: 0, ny: 0, nz: 0, pp: 0, deg: 1'b1};
                n_degenerate++;
                pending.push_back(r);
                return;
            end
            nn = '0;
            dotv = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = (n[i] < 0) ? 256'(-n[i]) : 256'(n[i]);
                nn = nn + m * m;
                dotv = dotv + n[i] * (p[3][i] - p[0][i]);
            end
            // t < 0 exactly when n.(p4-p1) > 0
            tneg = dotv > 0;
            num = ((dotv < 0) ? 256'(-dotv) : 256'(dotv)) << 16;
            quo = num / nn;
            rem = num % nn;
            if (2 * rem >= nn)
                quo = quo + 1;
            if (tneg)
            begin
                n_flipped++;
                if (quo > 256'h8000_0000)
                begin
                    quo = 256'h8000_0000;
                    n_saturated++;
                end
                r.pp = -quo[31:0];
            end
            else
            begin
                if (quo > 256'h7FFF_FFFF)
                begin
                    quo = 256'h7FFF_FFFF;
                    n_saturated++;
                end
                r.pp = quo[31:0];
            end
            r.nx = unit_component(n[0], nn, tneg);
            r.ny = unit_component(n[1], nn, tneg);
            r.nz = unit_component(n[2], nn, tneg);
            r.deg = 1'b0;
            pending.push_back(r);
        endfunction

        function void check_result(plane_res_t got);
            plane_res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            n_checked++;
            if (got.nx !== exp_r.nx)
            begin
                $error("normal_x: expected %0d, got %0d", exp_r.nx, got.nx);
                errors++;
            end
            if (got.ny !== exp_r.ny)
            begin
                $error("normal_y: expected %0d, got %0d", exp_r.ny, got.ny);
                errors++;
            end
            if (got.nz !== exp_r.nz)
            begin
                $error("normal_z: expected %0d, got %0d", exp_r.nz, got.nz);
                errors++;
            end
            if (got.pp !== exp_r.pp)
            begin
                $error("plane_param: expected %0d, got %0d", exp_r.pp, got.pp);
                errors++;
            end
            if (got.deg !== exp_r.deg)
            begin
                $error("degenerate: expected %0b, got %0b", exp_r.deg, got.deg);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    coords_t            pts;
    logic               done;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_param;
    logic               degenerate;

    plane_scoreboard    plane_sb;
    int                 n_sent;

    oriented_plane_normal u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .p1_x        (pts[0]),
        .p1_y        (pts[1]),
        .p1_z        (pts[2]),
        .p2_x        (pts[3]),
        .p2_y        (pts[4]),
        .p2_z        (pts[5]),
        .p3_x        (pts[6]),
        .p3_y        (pts[7]),
        .p3_z        (pts[8]),
        .ref_x       (pts[9]),
        .ref_y       (pts[10]),
        .ref_z       (pts[11]),
        .done        (done),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .plane_param (plane_param),
        .degenerate  (degenerate)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // requests and results are both taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                plane_sb.note_request(pts);
            if (done)
                plane_sb.check_result('{nx: normal_x, ny: normal_y, nz: normal_z,
                                        pp: plane_param, deg: degenerate});
        end
    end

    task automatic send_request(coords_t c, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        pts = c;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
    endtask

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom());
            1: return coord_t'($urandom_range(0, 16) - 8);
            default: return ($urandom_range(0, 1) != 0) ? coord_t'(16'sh7FFF)
                                                       : coord_t'(16'sh8000);
        endcase
    endfunction

    function automatic coords_t random_quad();
        coords_t c;
        int      mode;
        int      k;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            c[i] = rnd_coord((mode < 5) ? 0 : (mode < 7) ? 1 : $urandom_range(0, 2));
        // collinear or coincident first three points
        if (mode == 9)
        begin
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++)
            begin
                c[3 + i] = c[i] + coord_t'($urandom_range(0, 200) - 100);
                c[6 + i] = c[i] + coord_t'(k) * (c[3 + i] - c[i]);
            end
        end
        // reference point lying in the plane through p1
        else if (mode == 8 && $urandom_range(0, 1) != 0)
        begin
            for (int i = 0; i < 3; i++)
                c[9 + i] = c[i];
        end
        return c;
    endfunction

    function automatic coords_t mk(int v[12]);
        coords_t c;
        for (int i = 0; i < 12; i++)
            c[i] = coord_t'(v[i]);
        return c;
    endfunction

    initial
    begin
        #50ms;
        $display("timeout, %0d results outstanding", plane_sb.pending.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int      gap;
        int      idle_left;
        coords_t c;

        plane_sb = new();
        n_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        for (int i = 0; i < 12; i++)
            pts[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: axis normals, both orientations, in-plane reference,
        // saturation, collinear, coincident and extreme coordinates
        send_request(mk('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 5}), 0);
        send_request(mk('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -5}), 0);
        send_request(mk('{0, 0, 0, 1, 0, 0, 0, 1, 0, 7, -3, 0}), 0);
        send_request(mk('{0, 0, -32768, 1, 0, -32768, 0, 1, -32768, 0, 0, 32767}), 0);
        send_request(mk('{0, 0, 32767, 0, 1, 32767, 1, 0, 32767, 0, 0, -32768}), 0);
        send_request(mk('{1, 2, 3, 2, 4, 6, 3, 6, 9, 100, 0, 0}), 0);
        send_request(mk('{5, 5, 5, 5, 5, 5, 5, 5, 5, 0, 0, 0}), 0);
        send_request(mk('{0, 0, 0, 0, 1, 0, 0, 0, 1, 3, 0, 0}), 0);
        send_request(mk('{0, 0, 0, 0, 0, 1, 1, 0, 0, 0, -3, 0}), 0);
        send_request(mk('{-32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768, 32767, 32767, 32767}), 0);
        send_request(mk('{32767, 32767, 32767, -32768, 32767, 32767,
                          32767, -32768, 32767, -32768, -32768, -32768}), 0);
        send_request(mk('{-32768, 32767, -32768, 32767, -32768, 32767,
                          -1, 0, -1, 32767, 32767, -32768}), 0);
        send_request(mk('{0, 0, 0, 3, 4, 0, -4, 3, 0, 0, 0, 1}), 0);
        send_request(mk('{0, 0, 0, 1, 1, 1, 1, -1, 0, -1, -1, -1}), 0);
        send_request(mk('{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0}), 0);
        send_request(mk('{-1, 0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0}), 0);

        idle_left = 0;
        for (int n = 0; n < 1500; n++)
        begin
            // hold off until the pipeline has drained
            if (n == 700)
            begin
                @(negedge clk);
                start = 1'b0;
                while (plane_sb.pending.size() != 0)
                    @(negedge clk);
            end
            gap = 0;
            if (n < 1250)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if ($urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 5);
                else if ($urandom_range(0, 9) == 0)
                    idle_left = $urandom_range(5, 40);
            end
            c = random_quad();
            send_request(c, gap);
        end
        @(negedge clk);
        start = 1'b0;

        while (plane_sb.pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);

        $display("%0d requests sent, %0d results checked", n_sent, plane_sb.n_checked);
        $display("%0d degenerate, %0d flipped normals, %0d saturated parameters",
                 plane_sb.n_degenerate, plane_sb.n_flipped, plane_sb.n_saturated);
        if (plane_sb.errors == 0 && plane_sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/opn_pkg.sv
design/oriented_plane_normal.sv
tb/tb_oriented_plane_normal.sv
